### src/twsm_pkg.sv
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants of the two-wire measurement master
// Holds the item, result and configuration types, the status codes and the
// register indexes used by all modules of the block.
// ----------------------------------------------------------------------------
package twsm_pkg;

    localparam int unsigned HALF_W    = 16;
    localparam int unsigned TIMEOUT_W = 20;
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned WORD_W    = 16;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd250000;
    localparam logic [3:0]           RESET_PULSES  = 4'd9;
    localparam logic [3:0]           BITS_PER_BYTE = 4'd8;
    localparam logic [1:0]           READ_BYTES    = 2'd3;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_HALF_PERIOD = 1'b0;
    localparam t_cfg_idx CFG_TIMEOUT     = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NO_ACK  = 2'd1;
    localparam t_status ST_TIMEOUT = 2'd2;

    typedef logic t_opcode;
    localparam t_opcode OP_TICK  = 1'b0;
    localparam t_opcode OP_START = 1'b1;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] command_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic              scl_out;
        logic              sda_pull_low;
        logic              busy_res;
        logic              done_res;
        t_status           status;
        logic [WORD_W-1:0] measured_word;
    } t_result;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period_ticks;
        logic [TIMEOUT_W-1:0] ready_timeout_ticks;
    } t_cfg;

endpackage

### src/twsm_ifs.sv
// ----------------------------------------------------------------------------
// twsm_ifs: request channels of the two-wire measurement master
// Tick input channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface twsm_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] command_byte;
    logic       sda_in;

    modport source (output valid, output opcode, output command_byte, output sda_in,
                    input ready);
    modport sink   (input valid, input opcode, input command_byte, input sda_in,
                    output ready);
endinterface

interface twsm_out_if;
    logic        valid;
    logic        ready;
    logic        scl_out;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] measured_word;

    modport source (output valid, output scl_out, output sda_pull_low, output busy_res,
                    output done_res, output status, output measured_word, input ready);
    modport sink   (input valid, input scl_out, input sda_pull_low, input busy_res,
                    input done_res, input status, input measured_word, output ready);
endinterface

interface twsm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [19:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/twsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// twsm_cfg_regs: configuration registers
// Holds the half period and the ready timeout, written through the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module twsm_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  twsm_pkg::t_cfg_idx i_idx,
    input  logic [twsm_pkg::CFG_W-1:0] i_data,
    output twsm_pkg::t_cfg  o_cfg
);
    import twsm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks   <= HALF_RESET;
            r_cfg.ready_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_wr) begin
            case (i_idx)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks   <= i_data[HALF_W-1:0];
                CFG_TIMEOUT:     r_cfg.ready_timeout_ticks <= i_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/twsm_step.sv
// ----------------------------------------------------------------------------
// twsm_step: per-tick sequencer of the two-wire measurement master
// Computes the line levels and the completion report of one tick from the
// registered tick request and advances the transaction state when stepped.
// ----------------------------------------------------------------------------
module twsm_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  twsm_pkg::t_item   i_item,
    input  twsm_pkg::t_cfg    i_cfg,
    output twsm_pkg::t_result o_res
);
    import twsm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST1   = 5'd1,
        PH_ST2   = 5'd2,
        PH_ST3   = 5'd3,
        PH_ST4   = 5'd4,
        PH_ST5   = 5'd5,
        PH_ST6   = 5'd6,
        PH_WR_LO = 5'd7,
        PH_WR_HI = 5'd8,
        PH_AK_LO = 5'd9,
        PH_AK_HI = 5'd10,
        PH_RS_LO = 5'd11,
        PH_RS_HI = 5'd12,
        PH_POLL  = 5'd13,
        PH_RD_LO = 5'd14,
        PH_RD_HI = 5'd15,
        PH_RA_LO = 5'd16,
        PH_RA_HI = 5'd17
    } t_phase;

    t_phase               r_phase, e_phase, n_phase;
    logic [3:0]           r_bit_count, e_bit_count, n_bit_count;
    logic [1:0]           r_byte_count, e_byte_count, n_byte_count;
    logic [3:0]           r_pulse_count, e_pulse_count, n_pulse_count;
    logic [7:0]           r_shift_byte, e_shift_byte, n_shift_byte;
    logic [WORD_W-1:0]    r_result_word, e_result_word, n_result_word;
    logic [HALF_W-1:0]    r_delay_count, e_delay_count, n_delay_count;
    logic [TIMEOUT_W-1:0] r_wait_count, e_wait_count, n_wait_count;

    logic                 w_start;
    logic [HALF_W-1:0]    w_hp;
    logic [TIMEOUT_W-1:0] w_to;
    logic [TIMEOUT_W-1:0] w_wait_inc;
    logic                 w_hold;
    logic [3:0]           w_bit_inc;
    logic [3:0]           w_pulse_inc;
    logic [1:0]           w_byte_inc;
    logic                 w_scl;
    logic                 w_sda_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_byte_count  <= '0;
            r_pulse_count <= '0;
            r_shift_byte  <= '0;
            r_result_word <= '0;
            r_delay_count <= '0;
            r_wait_count  <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_byte_count  <= n_byte_count;
            r_pulse_count <= n_pulse_count;
            r_shift_byte  <= n_shift_byte;
            r_result_word <= n_result_word;
            r_delay_count <= n_delay_count;
            r_wait_count  <= n_wait_count;
        end
    end

    // A start request in idle opens the transaction on this very tick.
    always_comb begin
        w_start       = (r_phase == PH_IDLE) && (i_item.opcode == OP_START);
        e_phase       = w_start ? PH_ST1 : r_phase;
        e_bit_count   = w_start ? 4'd0 : r_bit_count;
        e_byte_count  = w_start ? 2'd0 : r_byte_count;
        e_pulse_count = w_start ? 4'd0 : r_pulse_count;
        e_shift_byte  = w_start ? i_item.command_byte : r_shift_byte;
        e_result_word = w_start ? '0 : r_result_word;
        e_delay_count = w_start ? '0 : r_delay_count;
        e_wait_count  = w_start ? '0 : r_wait_count;
    end

    assign w_hp = (i_cfg.half_period_ticks == '0) ? HALF_W'(1) : i_cfg.half_period_ticks;
    assign w_to = (i_cfg.ready_timeout_ticks == '0) ? TIMEOUT_W'(1)
                                                    : i_cfg.ready_timeout_ticks;
    assign w_wait_inc  = e_wait_count + TIMEOUT_W'(1);
    assign w_hold      = ({1'b0, e_delay_count} + 17'd1) < {1'b0, w_hp};
    assign w_bit_inc   = e_bit_count + 4'd1;
    assign w_pulse_inc = e_pulse_count + 4'd1;
    assign w_byte_inc  = e_byte_count + 2'd1;

    // Line levels held during the current phase.
    always_comb begin
        w_scl     = 1'b0;
        w_sda_low = 1'b0;
        case (e_phase)
            PH_ST1: w_sda_low = 1'b0;
            PH_ST2: w_scl = 1'b1;
            PH_ST3: begin
                w_scl     = 1'b1;
                w_sda_low = 1'b1;
            end
            PH_ST4: w_sda_low = 1'b1;
            PH_ST5: begin
                w_scl     = 1'b1;
                w_sda_low = 1'b1;
            end
            PH_ST6: w_scl = 1'b1;
            PH_WR_LO: w_sda_low = ~e_shift_byte[7];
            PH_WR_HI: begin
                w_scl     = 1'b1;
                w_sda_low = ~e_shift_byte[7];
            end
            PH_RA_LO: w_sda_low = (e_byte_count < 2'd2);
            PH_RA_HI: begin
                w_scl     = 1'b1;
                w_sda_low = (e_byte_count < 2'd2);
            end
            PH_AK_HI, PH_RS_HI, PH_RD_HI: w_scl = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_phase       = e_phase;
        n_bit_count   = e_bit_count;
        n_byte_count  = e_byte_count;
        n_pulse_count = e_pulse_count;
        n_shift_byte  = e_shift_byte;
        n_result_word = e_result_word;
        n_delay_count = e_delay_count;
        n_wait_count  = e_wait_count;
        o_res.scl_out       = w_scl;
        o_res.sda_pull_low  = w_sda_low;
        o_res.busy_res      = (e_phase != PH_IDLE);
        o_res.done_res      = 1'b0;
        o_res.status        = ST_OK;
        o_res.measured_word = '0;

        if (e_phase == PH_POLL) begin
            if (!i_item.sda_in) begin
                n_phase       = PH_RD_LO;
                n_bit_count   = 4'd0;
                n_shift_byte  = 8'd0;
                n_delay_count = '0;
            end else begin
                n_wait_count = w_wait_inc;
                if (w_wait_inc >= w_to) begin
                    o_res.done_res = 1'b1;
                    o_res.status   = ST_TIMEOUT;
                    n_phase        = PH_IDLE;
                end
            end
        end else if (e_phase != PH_IDLE) begin
            if (w_hold) begin
                n_delay_count = e_delay_count + HALF_W'(1);
            end else begin
                n_delay_count = '0;
                case (e_phase)
                    PH_ST1:   n_phase = PH_ST2;
                    PH_ST2:   n_phase = PH_ST3;
                    PH_ST3:   n_phase = PH_ST4;
                    PH_ST4:   n_phase = PH_ST5;
                    PH_ST5:   n_phase = PH_ST6;
                    PH_ST6: begin
                        // After the nine recovery pulses the start pattern ends the run.
                        if (e_pulse_count == RESET_PULSES) begin
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_NO_ACK;
                            n_phase        = PH_IDLE;
                        end else begin
                            n_phase = PH_WR_LO;
                        end
                    end
                    PH_WR_LO: n_phase = PH_WR_HI;
                    PH_WR_HI: begin
                        n_shift_byte = {e_shift_byte[6:0], 1'b0};
                        n_bit_count  = w_bit_inc;
                        n_phase      = (w_bit_inc >= BITS_PER_BYTE) ? PH_AK_LO : PH_WR_LO;
                    end
                    PH_AK_LO: n_phase = PH_AK_HI;
                    PH_AK_HI: begin
                        if (!i_item.sda_in) begin
                            n_wait_count = '0;
                            n_phase      = PH_POLL;
                        end else begin
                            n_pulse_count = 4'd0;
                            n_phase       = PH_RS_LO;
                        end
                    end
                    PH_RS_LO: n_phase = PH_RS_HI;
                    PH_RS_HI: begin
                        n_pulse_count = w_pulse_inc;
                        n_phase       = (w_pulse_inc >= RESET_PULSES) ? PH_ST1 : PH_RS_LO;
                    end
                    PH_RD_LO: n_phase = PH_RD_HI;
                    PH_RD_HI: begin
                        n_shift_byte = {e_shift_byte[6:0], i_item.sda_in};
                        n_bit_count  = w_bit_inc;
                        n_phase      = (w_bit_inc >= BITS_PER_BYTE) ? PH_RA_LO : PH_RD_LO;
                    end
                    PH_RA_LO: n_phase = PH_RA_HI;
                    PH_RA_HI: begin
                        if (e_byte_count == 2'd0) begin
                            n_result_word = {e_shift_byte, 8'd0};
                        end else if (e_byte_count == 2'd1) begin
                            n_result_word = {e_result_word[15:8], e_shift_byte};
                        end
                        n_byte_count = w_byte_inc;
                        // The third byte is the checksum and is dropped.
                        if (w_byte_inc >= READ_BYTES) begin
                            o_res.done_res      = 1'b1;
                            o_res.status        = ST_OK;
                            o_res.measured_word = n_result_word;
                            n_phase             = PH_IDLE;
                        end else begin
                            n_bit_count  = 4'd0;
                            n_shift_byte = 8'd0;
                            n_phase      = PH_RD_LO;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("completed transaction did not return to idle");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_delay_count) && $stable(r_wait_count)))
        else $error("state moved without a tick");

    a_word_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.measured_word != '0) |-> (o_res.done_res && o_res.status == ST_OK))
        else $error("word reported outside a successful completion");

    a_pulse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse_count <= RESET_PULSES))
        else $error("recovery pulse count overran");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> (o_res.busy_res && (o_res.status == ST_OK ||
            o_res.status == ST_NO_ACK || o_res.status == ST_TIMEOUT)))
        else $error("completion without an active transaction");
`endif

endmodule

### src/two_wire_sensor_measure_master.sv
// Each tick request is held in the input register; its result goes to the result register.
// Throughput: one tick request per cycle when the output is not stalled; the sequencer
// step is combinational between the input register and the result register.
// Output stall holds both registers; the input side takes a new request whenever
// the input register is empty or moves on in the same cycle.
// Reset (synchronous, active low) returns to idle with half period 1, timeout 250000.
// ----------------------------------------------------------------------------
// two_wire_sensor_measure_master: two-wire measurement master, top level
// Registers each tick request, runs one sequencer step on it and registers the
// line levels and completion report as the result.
// ----------------------------------------------------------------------------
module two_wire_sensor_measure_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twsm_in_if.sink     i_in,
    twsm_out_if.source  o_res,
    twsm_cfg_if.sink    i_cfg
);
    import twsm_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    logic    w_step;
    logic    w_in_take;
    t_cfg    w_cfg;
    t_result w_res;

    assign w_step    = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_take = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.opcode       <= i_in.opcode;
            r_item.command_byte <= i_in.command_byte;
            r_item.sda_in       <= i_in.sda_in;
        end
        if (w_step) begin
            r_res <= w_res;
        end
    end

    twsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    twsm_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_res.valid         = r_out_valid;
    assign o_res.scl_out       = r_res.scl_out;
    assign o_res.sda_pull_low  = r_res.sda_pull_low;
    assign o_res.busy_res      = r_res.busy_res;
    assign o_res.done_res      = r_res.done_res;
    assign o_res.status        = r_res.status;
    assign o_res.measured_word = r_res.measured_word;

endmodule

### dv/tb_two_wire_sensor_measure_master.sv
// ----------------------------------------------------------------------------
// tb_two_wire_sensor_measure_master: tick-level check of the measurement master
// A sensor-aware generator queues tick requests that walk the block through
// start patterns, command bits, acknowledge, polling, data reads, reset pulses
// and timeouts. A sequencer model predicts the line levels and the completion
// report of every accepted tick, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_two_wire_sensor_measure_master;
    import twsm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_TICKS = 1450;

    typedef enum logic [4:0] {
        SQ_IDLE = 5'd0, SQ_START1, SQ_START2, SQ_START3, SQ_START4, SQ_START5, SQ_START6,
        SQ_CMD_LO, SQ_CMD_HI, SQ_ACK_LO, SQ_ACK_HI, SQ_RST_LO, SQ_RST_HI, SQ_POLL,
        SQ_DATA_LO, SQ_DATA_HI, SQ_MACK_LO, SQ_MACK_HI
    } t_seq_phase;

    typedef enum int { DATA_RANDOM, DATA_ONES, DATA_ZEROS } t_data_kind;

    typedef struct packed {
        t_seq_phase  phase;
        logic [3:0]  bits;
        logic [1:0]  bytes;
        logic [3:0]  pulses;
        logic [7:0]  shreg;
        logic [15:0] word;
        logic [15:0] hold;
        logic [19:0] poll;
        logic        scl;
        logic        sda_low;
    } t_seq_state;

    logic i_clk;
    logic i_rst_n;

    twsm_in_if  tick_if ();
    twsm_out_if res_if ();
    twsm_cfg_if reg_if ();

    two_wire_sensor_measure_master dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_res   (res_if),
        .i_cfg   (reg_if)
    );

    t_item       pending_ticks[$];
    t_result     expected_results[$];
    t_cfg        cur_cfg;
    t_seq_state  gen_state;
    t_seq_state  chk_state;
    logic        tick_taken;
    logic        reg_taken;
    bit          steady;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned mismatches;
    int unsigned queued_ticks;
    int unsigned cycles;

    always #5 i_clk = ~i_clk;

    // One sequencer step per tick: lines come from the phase held at the start
    // of the tick, then the phase moves on.
    function automatic t_result sequencer_step(inout t_seq_state s, input t_cfg c,
                                               input t_item it);
        int unsigned hp;
        int unsigned to;
        t_result     r;
        hp = (c.half_period_ticks == 0) ? 1 : c.half_period_ticks;
        to = (c.ready_timeout_ticks == 0) ? 1 : c.ready_timeout_ticks;
        r  = '0;
        if (s.phase == SQ_IDLE && it.opcode == OP_START) begin
            s.shreg  = it.command_byte;
            s.bits   = '0;
            s.bytes  = '0;
            s.pulses = '0;
            s.word   = '0;
            s.hold   = '0;
            s.poll   = '0;
            s.phase  = SQ_START1;
        end
        if (s.phase == SQ_IDLE) begin
            s.scl     = 1'b0;
            s.sda_low = 1'b0;
        end else begin
            r.busy_res = 1'b1;
            {s.scl, s.sda_low} = 2'b00;
            case (s.phase)
                SQ_START2, SQ_START6: {s.scl, s.sda_low} = 2'b10;
                SQ_START3, SQ_START5: {s.scl, s.sda_low} = 2'b11;
                SQ_START4:            {s.scl, s.sda_low} = 2'b01;
                SQ_CMD_LO, SQ_CMD_HI: begin
                    s.scl     = (s.phase == SQ_CMD_HI);
                    s.sda_low = ~s.shreg[7];
                end
                SQ_MACK_LO, SQ_MACK_HI: begin
                    s.scl     = (s.phase == SQ_MACK_HI);
                    s.sda_low = (s.bytes < 2'd2);
                end
                SQ_ACK_HI, SQ_RST_HI, SQ_DATA_HI: s.scl = 1'b1;
                default: ;
            endcase
            if (s.phase == SQ_POLL) begin
                if (!it.sda_in) begin
                    s.phase = SQ_DATA_LO;
                    s.bits  = '0;
                    s.shreg = '0;
                    s.hold  = '0;
                end else begin
                    s.poll = s.poll + 20'd1;
                    if (s.poll >= to) begin
                        r.done_res = 1'b1;
                        r.status   = ST_TIMEOUT;
                        s.phase    = SQ_IDLE;
                    end
                end
            end else if (int'(s.hold) + 1 < hp) begin
                s.hold = s.hold + 16'd1;
            end else begin
                s.hold = '0;
                case (s.phase)
                    SQ_START6: begin
                        // The start after the reset pulses closes a failed transfer.
                        if (s.pulses == RESET_PULSES) begin
                            r.done_res = 1'b1;
                            r.status   = ST_NO_ACK;
                            s.phase    = SQ_IDLE;
                        end else begin
                            s.phase = SQ_CMD_LO;
                        end
                    end
                    SQ_CMD_HI: begin
                        s.shreg = {s.shreg[6:0], 1'b0};
                        s.bits  = s.bits + 4'd1;
                        s.phase = (s.bits >= BITS_PER_BYTE) ? SQ_ACK_LO : SQ_CMD_LO;
                    end
                    SQ_ACK_HI: begin
                        if (!it.sda_in) begin
                            s.poll  = '0;
                            s.phase = SQ_POLL;
                        end else begin
                            s.pulses = '0;
                            s.phase  = SQ_RST_LO;
                        end
                    end
                    SQ_RST_HI: begin
                        s.pulses = s.pulses + 4'd1;
                        s.phase  = (s.pulses >= RESET_PULSES) ? SQ_START1 : SQ_RST_LO;
                    end
                    SQ_DATA_HI: begin
                        s.shreg = {s.shreg[6:0], it.sda_in};
                        s.bits  = s.bits + 4'd1;
                        s.phase = (s.bits >= BITS_PER_BYTE) ? SQ_MACK_LO : SQ_DATA_LO;
                    end
                    SQ_MACK_HI: begin
                        if (s.bytes == 2'd0)
                            s.word = {s.shreg, 8'h00};
                        else if (s.bytes == 2'd1)
                            s.word = s.word | {8'h00, s.shreg};
                        s.bytes = s.bytes + 2'd1;
                        if (s.bytes >= READ_BYTES) begin
                            r.done_res      = 1'b1;
                            r.status        = ST_OK;
                            r.measured_word = s.word;
                            s.phase         = SQ_IDLE;
                        end else begin
                            s.bits  = '0;
                            s.shreg = '0;
                            s.phase = SQ_DATA_LO;
                        end
                    end
                    default: s.phase = t_seq_phase'(s.phase + 5'd1);
                endcase
            end
        end
        r.scl_out      = s.scl;
        r.sda_pull_low = s.sda_low;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // The generator tracks the sequencer too, so that the sensor side can answer
    // the acknowledge, the poll and the data bits at the right ticks.
    task automatic push_tick(input t_opcode op, input logic [7:0] cmd, input logic sda);
        t_item it;
        it.opcode       = op;
        it.command_byte = cmd;
        it.sda_in       = sda;
        void'(sequencer_step(gen_state, cur_cfg, it));
        pending_ticks.push_back(it);
        queued_ticks++;
    endtask

    task automatic queue_quiet_ticks(input int unsigned n);
        repeat (n) push_tick(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic queue_measurement(input logic [7:0] cmd, input bit acked,
                                     input bit stall_poll, input t_data_kind kind,
                                     input int unsigned max_len);
        int unsigned n;
        logic        sda;
        push_tick(OP_START, cmd, 1'($urandom));
        n = 1;
        while (gen_state.phase != SQ_IDLE && n < max_len) begin
            case (gen_state.phase)
                SQ_ACK_HI:  sda = !acked;
                SQ_POLL:    sda = stall_poll ? 1'b1 : ($urandom_range(2) != 0);
                SQ_DATA_HI: sda = (kind == DATA_ONES) ? 1'b1 :
                                  (kind == DATA_ZEROS) ? 1'b0 : 1'($urandom);
                default:    sda = 1'($urandom);
            endcase
            // Now and then a start arrives while busy and must be ignored.
            if ($urandom_range(99) < 3)
                push_tick(OP_START, 8'($urandom), sda);
            else
                push_tick(OP_TICK, 8'($urandom), sda);
            n++;
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [19:0] data);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= data;
        do @(negedge i_clk); while (!reg_taken);
        reg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained;
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || tick_if.valid || expected_results.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // Tick request driver.
    always @(negedge i_clk) begin : tick_driver
        t_item nxt;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else if (!tick_if.valid || tick_taken) begin
            if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
                nxt = pending_ticks.pop_front();
                tick_if.valid        <= 1'b1;
                tick_if.opcode       <= nxt.opcode;
                tick_if.command_byte <= nxt.command_byte;
                tick_if.sda_in       <= nxt.sda_in;
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with the long hold-off counted here.
    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_item   it;
        t_result got;
        t_result want;
        tick_taken <= i_rst_n && tick_if.valid && tick_if.ready;
        reg_taken  <= i_rst_n && reg_if.valid && reg_if.ready;
        if (i_rst_n && reg_if.valid && reg_if.ready) begin
            if (reg_if.index == CFG_HALF_PERIOD)
                cur_cfg.half_period_ticks = reg_if.data[15:0];
            else
                cur_cfg.ready_timeout_ticks = reg_if.data;
        end
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            it.opcode       = tick_if.opcode;
            it.command_byte = tick_if.command_byte;
            it.sda_in       = tick_if.sda_in;
            expected_results.push_back(sequencer_step(chk_state, cur_cfg, it));
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.scl_out       = res_if.scl_out;
            got.sda_pull_low  = res_if.sda_pull_low;
            got.busy_res      = res_if.busy_res;
            got.done_res      = res_if.done_res;
            got.status        = res_if.status;
            got.measured_word = res_if.measured_word;
            if (expected_results.size() == 0) begin
                $error("result with no tick request pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("scl_out", 16'(want.scl_out), 16'(got.scl_out));
                check_field("sda_pull_low", 16'(want.sda_pull_low), 16'(got.sda_pull_low));
                check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("measured_word", want.measured_word, got.measured_word);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_two_wire_sensor_measure_master failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] hp;
        logic [19:0] to;
        bit          stall;
        t_data_kind  kind;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        tick_if.valid        = 1'b0;
        tick_if.opcode       = OP_TICK;
        tick_if.command_byte = '0;
        tick_if.sda_in       = 1'b0;
        res_if.ready         = 1'b0;
        reg_if.valid         = 1'b0;
        reg_if.index         = CFG_HALF_PERIOD;
        reg_if.data          = '0;
        tick_taken           = 1'b0;
        reg_taken            = 1'b0;
        steady               = 1'b0;
        hold_req             = 0;
        hold_seen            = 0;
        hold_left            = 0;
        mismatches           = 0;
        queued_ticks         = 0;
        cycles               = 0;
        gen_state            = '0;
        chk_state            = '0;
        cur_cfg.half_period_ticks   = HALF_RESET;
        cur_cfg.ready_timeout_ticks = TIMEOUT_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero registers behave as one: the first poll tick with the line high
        // times out, then a refused command runs the reset pulses.
        write_reg(CFG_HALF_PERIOD, 20'h0);
        write_reg(CFG_TIMEOUT, 20'h0);
        push_tick(OP_TICK, 8'h00, 1'b0);
        push_tick(OP_TICK, 8'hFF, 1'b1);
        queue_measurement(8'hFF, 1'b1, 1'b1, DATA_RANDOM, 200);
        queue_measurement(8'h00, 1'b0, 1'b0, DATA_RANDOM, 200);
        wait_drained();
        write_reg(CFG_HALF_PERIOD, 20'hF0001);
        write_reg(CFG_TIMEOUT, 20'd6);
        queue_measurement(8'hA5, 1'b1, 1'b0, DATA_ONES, 400);
        queue_measurement(8'h5A, 1'b1, 1'b0, DATA_ZEROS, 400);
        wait_drained();

        // Results are held off while requests keep coming, so the input stalls.
        write_reg(CFG_TIMEOUT, 20'hFFFFF);
        steady = 1'b1;
        hold_req++;
        repeat (3) queue_measurement(8'($urandom), 1'b1, 1'b0, DATA_RANDOM, 1000);
        wait_drained();
        steady = 1'b0;

        // A very long half period is cut short mid-hold by a smaller one.
        write_reg(CFG_HALF_PERIOD, 20'h0FFFF);
        write_reg(CFG_TIMEOUT, 20'($urandom_range(1, 40)));
        queue_measurement(8'($urandom), 1'b1, 1'b0, DATA_RANDOM, 40);
        wait_drained();
        write_reg(CFG_HALF_PERIOD, 20'd2);
        queue_measurement(8'($urandom), 1'b1, 1'b0, DATA_RANDOM, 1000);
        wait_drained();

        while (queued_ticks < RANDOM_TICKS) begin
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: hp = 16'd1;
                    6:                hp = 16'd2;
                    7:                hp = 16'd3;
                    8:                hp = 16'($urandom_range(1, 5));
                    default:          hp = 16'd0;
                endcase
                case ($urandom_range(3))
                    0:       to = 20'($urandom_range(1, 8));
                    1:       to = 20'($urandom_range(9, 200));
                    2:       to = 20'hFFFFF;
                    default: to = 20'($urandom);
                endcase
                write_reg(CFG_HALF_PERIOD, {4'($urandom), hp});
                write_reg(CFG_TIMEOUT, to);
            end
            steady = ($urandom_range(4) == 0);
            repeat ($urandom_range(1, 3)) begin
                queue_quiet_ticks($urandom_range(0, 4));
                stall = (cur_cfg.ready_timeout_ticks <= 500) && ($urandom_range(6) == 0);
                case ($urandom_range(7))
                    0:       kind = DATA_ONES;
                    1:       kind = DATA_ZEROS;
                    default: kind = DATA_RANDOM;
                endcase
                // A short cap leaves a transfer open across the next register write.
                queue_measurement(8'($urandom), $urandom_range(99) < 85, stall, kind,
                                  ($urandom_range(9) == 0) ? $urandom_range(5, 60) : 1000);
            end
            wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb_two_wire_sensor_measure_master passed");
        else
            $display("tb_two_wire_sensor_measure_master failed");
        $finish;
    end

endmodule

### two_wire_sensor_measure_master.f
src/twsm_pkg.sv
src/twsm_ifs.sv
src/twsm_cfg_regs.sv
src/twsm_step.sv
src/two_wire_sensor_measure_master.sv
dv/tb_two_wire_sensor_measure_master.sv
